### design/assert_macros.svh
// Assertion macros used by the checker file hsv_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define CHK_RUN(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checked at every clock edge, reset included.
`define CHK_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

### design/hsv_pkg.sv
// Package with the widths and pipeline payload type of the RGB to HSV converter.
package hsv_pkg;

  localparam int unsigned DivSteps = 9;

  typedef struct packed {
    logic [7:0]  value_level;
    logic [19:0] hue_rem;
    logic [18:0] hue_den;
    logic [8:0]  hue_q;
    logic [15:0] sat_rem;
    logic [15:0] sat_den;
    logic [8:0]  sat_q;
  } div_t;

endpackage

### design/hsv_front.sv
// Front stages: maximum, minimum and sector offset, then the dividend and divisor setup.
module hsv_front import hsv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       angle_mode,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic       out_valid,
  input  logic       out_ready,
  output div_t       out_data
);

  logic [7:0]  mx_c;
  logic [7:0]  mn_c;
  logic [7:0]  delta_c;
  logic [11:0] t_c;
  logic [11:0] d12;
  logic [11:0] six12;

  logic        valid1;
  logic        ready1;
  logic [7:0]  mx1;
  logic [7:0]  delta1;
  logic [10:0] t1;

  logic [19:0] t20;
  logic [10:0] six11;
  div_t        data2_next;

  always_comb begin
    mx_c = red;
    mn_c = red;
    if (green > mx_c) mx_c = green;
    if (blue > mx_c) mx_c = blue;
    if (green < mn_c) mn_c = green;
    if (blue < mn_c) mn_c = blue;
    delta_c = mx_c - mn_c;
    d12 = {4'b0, delta_c};
    six12 = (d12 << 2) + (d12 << 1);
    priority if (red == mx_c) begin
      t_c = {4'b0, green} - {4'b0, blue};
      if (t_c[11]) t_c = t_c + six12;
    end else if (green == mx_c) begin
      t_c = (d12 << 1) + {4'b0, blue} - {4'b0, red};
    end else begin
      t_c = (d12 << 2) + {4'b0, red} - {4'b0, green};
    end
  end

  assign in_ready = !valid1 || ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (in_ready) begin
      valid1 <= in_valid;
    end
    if (in_ready && in_valid) begin
      mx1 <= mx_c;
      delta1 <= delta_c;
      t1 <= t_c[10:0];
    end
  end

  always_comb begin
    t20 = {9'b0, t1};
    six11 = ({3'b0, delta1} << 2) + ({3'b0, delta1} << 1);
    data2_next.value_level = mx1;
    if (angle_mode) begin
      data2_next.hue_rem = t20 << 8;
    end else begin
      data2_next.hue_rem = (t20 << 8) + (t20 << 6) + (t20 << 5) + (t20 << 3);
    end
    data2_next.sat_rem = {delta1, 8'b0} - {8'b0, delta1};
    if (delta1 == 8'd0) begin
      data2_next.hue_den = '1;
      data2_next.sat_den = '1;
    end else begin
      data2_next.hue_den = {six11, 8'b0};
      data2_next.sat_den = {mx1, 8'b0};
    end
    data2_next.hue_q = '0;
    data2_next.sat_q = '0;
  end

  assign ready1 = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready1) begin
      out_valid <= valid1;
    end
    if (ready1 && valid1) begin
      out_data <= data2_next;
    end
  end

endmodule

### design/hsv_div_stage.sv
// One restoring division step for both the hue and the saturation quotient.
module hsv_div_stage import hsv_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  div_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output div_t out_data
);

  div_t data_next;

  always_comb begin
    data_next = in_data;
    if ({1'b0, in_data.hue_den} <= in_data.hue_rem) begin
      data_next.hue_rem = in_data.hue_rem - {1'b0, in_data.hue_den};
      data_next.hue_q = {in_data.hue_q[7:0], 1'b1};
    end else begin
      data_next.hue_q = {in_data.hue_q[7:0], 1'b0};
    end
    if (in_data.sat_den <= in_data.sat_rem) begin
      data_next.sat_rem = in_data.sat_rem - in_data.sat_den;
      data_next.sat_q = {in_data.sat_q[7:0], 1'b1};
    end else begin
      data_next.sat_q = {in_data.sat_q[7:0], 1'b0};
    end
    data_next.hue_den = in_data.hue_den >> 1;
    data_next.sat_den = in_data.sat_den >> 1;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

### design/rgb_to_hsv_integer.sv
// Top level of the 8-bit RGB to HSV converter.
//
// Pixels arrive on the s_axis channel and results leave on the m_axis
// channel; a transfer takes place when tvalid and tready are both high.
// The cfg channel writes angle_mode (0: hue in degrees, 1: hue in 1/256
// turns); cfg_ready is always high. Write it only while idle; the block does not enforce this.
// The pipeline has eleven register stages: two front stages find the
// maximum, minimum and sector and set up dividend and divisor, then nine
// stages each resolve one quotient bit of the hue and saturation dividers.
// m_axis_tvalid rises once a pixel has passed the two front stages and the
// nine divider stages, and one pixel is taken per cycle while the receiver
// keeps up.
// When the receiver stalls, each stage holds its item and accepts a new one
// only when it is empty or moving on, so bubbles are squeezed out and
// nothing is lost or repeated.
// Reset clears all valid bits and sets angle_mode to degrees.
module rgb_to_hsv_integer import hsv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,       // angle_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // hue[8:0], saturation[16:9],
                                      // value_level[24:17], zero[31:25]
);

  logic angle_mode;
  logic valid_chain [DivSteps+1];
  logic ready_chain [DivSteps+1];
  div_t data_chain  [DivSteps+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_mode <= 1'b0;
    end else if (cfg_valid) begin
      angle_mode <= cfg_data;
    end
  end

  hsv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .angle_mode (angle_mode),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .red        (s_axis_tdata[7:0]),
    .green      (s_axis_tdata[15:8]),
    .blue       (s_axis_tdata[23:16]),
    .out_valid  (valid_chain[0]),
    .out_ready  (ready_chain[0]),
    .out_data   (data_chain[0])
  );

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    hsv_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid_chain[i]),
      .in_ready  (ready_chain[i]),
      .in_data   (data_chain[i]),
      .out_valid (valid_chain[i+1]),
      .out_ready (ready_chain[i+1]),
      .out_data  (data_chain[i+1])
    );
  end

  assign ready_chain[DivSteps] = m_axis_tready;
  assign m_axis_tvalid = valid_chain[DivSteps];
  assign m_axis_tdata = {7'b0, data_chain[DivSteps].value_level,
                         data_chain[DivSteps].sat_q[7:0],
                         data_chain[DivSteps].hue_q};

endmodule

### design/hsv_checker.sv
// Port-level checker for the RGB to HSV converter, bound to the top level.
`include "assert_macros.svh"

module hsv_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  `CHK_ALL(a_reset_empty, clk, rst |=> !m_axis_tvalid)
  `CHK_RUN(a_stall_valid, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `CHK_RUN(a_stall_data, clk, rst, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
  `CHK_RUN(a_grey_hue, clk, rst, m_axis_tvalid && m_axis_tdata[16:9] == 8'd0 |-> m_axis_tdata[8:0] == 9'd0)
  `CHK_RUN(a_hue_range, clk, rst, m_axis_tvalid |-> m_axis_tdata[8:0] < 9'd360)

endmodule

bind rgb_to_hsv_integer hsv_checker u_hsv_checker (.*);

### bench/tb_top.sv
// Self-checking testbench for the rgb_to_hsv_integer pixel converter.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {
    ANGLE_DEGREES = 1'b0,
    ANGLE_TURNS   = 1'b1
  } angle_mode_e;

  typedef struct {
    logic [8:0] hue;
    logic [7:0] saturation;
    logic [7:0] value_level;
  } hsv_t;

  localparam int MaxGap      = 12;
  localparam int DrainCycles = 16;
  localparam int IdleLimit   = 2000;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;    // red[7:0], green[15:8], blue[23:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;    // hue[8:0], saturation[16:9], value_level[24:17]

  hsv_t        pending_hsv[$];
  angle_mode_e angle_mode = ANGLE_DEGREES;
  bit          steady = 1'b0;
  int          rx_hold = 0;
  int          errors = 0;
  int          pixels_sent = 0;
  int          results_seen = 0;
  int          config_writes = 0;
  int          idle_cycles = 0;

  rgb_to_hsv_integer uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk = ~clk;

  function automatic hsv_t predict_hsv(input logic [7:0] red, input logic [7:0] green,
                                       input logic [7:0] blue, input angle_mode_e mode);
    int   rv, gv, bv, mx, mn, delta, offset, diff, circle, num, den;
    hsv_t res;
    rv = int'(red);
    gv = int'(green);
    bv = int'(blue);
    mx = rv;
    mn = rv;
    if (gv > mx) mx = gv;
    if (bv > mx) mx = bv;
    if (gv < mn) mn = gv;
    if (bv < mn) mn = bv;
    delta = mx - mn;
    res.value_level = mx[7:0];
    if (delta == 0) begin
      res.hue = '0;
      res.saturation = '0;
      return res;
    end
    res.saturation = 8'((delta * 255) / mx);
    if (rv == mx) begin
      offset = 0;
      diff = gv - bv;
    end else if (gv == mx) begin
      offset = 2;
      diff = bv - rv;
    end else begin
      offset = 4;
      diff = rv - gv;
    end
    circle = (mode == ANGLE_TURNS) ? 256 : 360;
    num = (offset * delta + diff) * circle;
    den = 6 * delta;
    if (num < 0) num += circle * den;
    if (num >= circle * den) num = 0;
    res.hue = 9'(num / den);
    return res;
  endfunction

  // Each result transfer is checked against the oldest prediction.
  always @(posedge clk) begin : check_results
    hsv_t want;
    hsv_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.hue = m_axis_tdata[8:0];
      got.saturation = m_axis_tdata[16:9];
      got.value_level = m_axis_tdata[24:17];
      if (pending_hsv.size() == 0) begin
        $error("result transfer with no pixel pending: hue %0d saturation %0d value_level %0d",
               got.hue, got.saturation, got.value_level);
        errors++;
      end else begin
        want = pending_hsv.pop_front();
        if (got.hue !== want.hue) begin
          $error("hue: expected %0d, actual %0d", want.hue, got.hue);
          errors++;
        end
        if (got.saturation !== want.saturation) begin
          $error("saturation: expected %0d, actual %0d", want.saturation, got.saturation);
          errors++;
        end
        if (got.value_level !== want.value_level) begin
          $error("value_level: expected %0d, actual %0d", want.value_level, got.value_level);
          errors++;
        end
      end
      results_seen++;
      rx_hold = steady ? 0 : $urandom_range(0, MaxGap);
    end
  end

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Timeout after %0d cycles without a transfer.", IdleLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {blue, green, red};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_hsv.push_back(predict_hsv(red, green, blue, angle_mode));
    pixels_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_hsv.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_angle_mode(input angle_mode_e mode);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    angle_mode = mode;
    config_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Most pixels are uniform unless corner_heavy is set; the rest force ties for the maximum or tiny spreads.
  task automatic send_random_pixel(input bit corner_heavy);
    logic [7:0] chan[3];
    int         pick, i, j, base;
    pick = corner_heavy ? $urandom_range(4, 9) : $urandom_range(0, 9);
    for (int k = 0; k < 3; k++) chan[k] = 8'($urandom_range(0, 255));
    if (pick >= 6 && pick <= 7) begin
      i = $urandom_range(0, 2);
      j = (i + $urandom_range(1, 2)) % 3;
      chan[i] = 8'($urandom_range(0, 255));
      chan[j] = chan[i];
      chan[3 - i - j] = 8'($urandom_range(0, chan[i]));
    end else if (pick >= 8) begin
      base = $urandom_range(0, 254);
      for (int k = 0; k < 3; k++) chan[k] = 8'(base + $urandom_range(0, 1));
    end
    send_pixel(chan[0], chan[1], chan[2]);
  endtask

  task automatic test_directed_pixels();
    logic [23:0] rgb_list[12] = '{
      24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00, 24'h0000FF,
      24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'h010000, 24'hFEFFFE
    };
    foreach (rgb_list[k]) send_pixel(rgb_list[k][23:16], rgb_list[k][15:8], rgb_list[k][7:0]);
    set_angle_mode(ANGLE_TURNS);
    foreach (rgb_list[k]) send_pixel(rgb_list[k][23:16], rgb_list[k][15:8], rgb_list[k][7:0]);
  endtask

  task automatic test_random_pixels(input angle_mode_e mode, input int count,
                                    input bit corner_heavy);
    set_angle_mode(mode);
    repeat (count) send_random_pixel(corner_heavy);
  endtask

  task automatic test_back_to_back(input angle_mode_e mode, input int count);
    set_angle_mode(mode);
    steady = 1'b1;
    repeat (count) send_random_pixel(1'b0);
    drain_results();
    steady = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_pixels();
    test_random_pixels(ANGLE_TURNS, 600, 1'b0);
    test_random_pixels(ANGLE_DEGREES, 600, 1'b0);
    test_back_to_back(ANGLE_TURNS, 300);
    test_random_pixels(ANGLE_DEGREES, 300, 1'b1);
    drain_results();

    $display("Sent %0d pixels and checked %0d results over %0d angle mode writes,",
             pixels_sent, results_seen, config_writes);
    $display("covering grey pixels, ties for the maximum, hue wrap and both hue units.");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/hsv_pkg.sv
design/hsv_front.sv
design/hsv_div_stage.sv
design/rgb_to_hsv_integer.sv
design/hsv_checker.sv
bench/tb_top.sv
